// ----- rtl/core/dbd_pkg.sv -----
`default_nettype none

package dbd_pkg;

   // Number format and row layout limits.
   localparam int FRAC_BITS   = 16;
   localparam int MAX_CLASSES = 255;

   localparam int VALUE_W = 32;
   localparam int CLASS_W = 8;
   localparam int POS_W   = 9;
   localparam logic [POS_W-1:0] POS_MAX = '1;

   // Configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] REG_LAYOUT_MODE    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_NUM_CLASSES    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_CONF_THRESHOLD = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_INV_SCALE      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_PAD_X          = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_PAD_Y          = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH    = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT   = 3'd7;

   // Layout codes; only the objectness layout changes the datapath.
   localparam logic [1:0] LAYOUT_PLAIN = 2'd0;
   localparam logic [1:0] LAYOUT_OBJ   = 2'd1;
   localparam logic [1:0] LAYOUT_ANGLE = 2'd2;

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Datapath widths.
   localparam int PAD_W    = 12;
   localparam int DIM_W    = 13;
   localparam int THR_W    = 17;
   localparam int INV_W    = 24;
   localparam int REL_W    = VALUE_W + 1;
   localparam int SZ_W     = VALUE_W + INV_W + 1;
   localparam int RINV_W   = REL_W + INV_W + 1;
   localparam int EDGE_W   = RINV_W + 2;
   localparam int N_W      = SZ_W - 2 * FRAC_BITS;
   localparam int LO_W     = EDGE_W - (2 * FRAC_BITS + 1);
   localparam int SUM_W    = LO_W + 1;
   localparam int PROD_W   = 2 * VALUE_W;
   localparam int CONF_W   = PROD_W - FRAC_BITS;
   localparam int CONF_OUT_W = 31;
   localparam int COORD_W  = 12;

   localparam logic [DIM_W-1:0] DIM_MAX = 13'd4096;

   localparam int RSP_FIELDS_W = 2 * COORD_W + 2 * DIM_W + CLASS_W + CONF_OUT_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef struct packed {
      logic [1:0]         layout_mode;
      logic [CLASS_W-1:0] num_classes;
      logic [THR_W-1:0]   conf_threshold;
      logic [INV_W-1:0]   inv_scale;
      logic [PAD_W-1:0]   pad_x;
      logic [PAD_W-1:0]   pad_y;
      logic [DIM_W-1:0]   frame_width;
      logic [DIM_W-1:0]   frame_height;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      layout_mode:    LAYOUT_PLAIN,
      num_classes:    8'd80,
      conf_threshold: 17'd16384,
      inv_scale:      24'd65536,
      pad_x:          12'd0,
      pad_y:          12'd0,
      frame_width:    13'd640,
      frame_height:   13'd640
   };

   // One finished prediction row, handed from the front to the back.
   typedef struct packed {
      logic signed [VALUE_W-1:0] best_score;
      logic [CLASS_W-1:0]        best_index;
      logic signed [VALUE_W-1:0] objectness;
      logic signed [REL_W-1:0]   rel_x;
      logic signed [REL_W-1:0]   rel_y;
      logic signed [VALUE_W-1:0] size_w;
      logic signed [VALUE_W-1:0] size_h;
      logic                      seen;
   } row_rec_type;

   // Result layout on rsp_tdata, box_left in the lowest bits.
   typedef struct packed {
      logic [RSP_DATA_W-RSP_FIELDS_W-1:0] fill;
      logic [CONF_OUT_W-1:0]              confidence;
      logic [CLASS_W-1:0]                 class_index;
      logic [DIM_W-1:0]                   box_height;
      logic [DIM_W-1:0]                   box_width;
      logic [COORD_W-1:0]                 box_top;
      logic [COORD_W-1:0]                 box_left;
   } rsp_fields_type;

endpackage

`default_nettype wire

// ----- rtl/core/dbd_front.sv -----
`default_nettype none

module dbd_front (
   input  logic                 clock,
   input  logic                 reset,
   input  dbd_pkg::cfg_type     cfg,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [31:0]          req_tdata,   // value
   input  logic                 req_tlast,   // row_end
   input  logic                 queue_full,
   output logic                 push,
   output dbd_pkg::row_rec_type push_rec
);
   import dbd_pkg::*;

   logic [POS_W-1:0]          position_ff, position_in;
   logic signed [VALUE_W-1:0] best_ff, best_in, best_upd;
   logic [CLASS_W-1:0]        index_ff, index_in, index_upd;
   logic signed [VALUE_W-1:0] box_ff [4];
   logic signed [VALUE_W-1:0] box_in [4];
   logic signed [VALUE_W-1:0] box_upd [4];
   logic signed [VALUE_W-1:0] obj_ff, obj_in, obj_upd;

   logic                      accept;
   logic                      has_obj;
   logic [POS_W-1:0]          base;
   logic [CLASS_W-1:0]        ncls;
   logic [POS_W:0]            class_end;
   logic                      in_class;
   logic [CLASS_W-1:0]        k;
   logic signed [VALUE_W-1:0] v;
   logic [REL_W-1:0]          pad_x_s, pad_y_s;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign push       = accept && req_tlast;
   assign v          = $signed(req_tdata);

   // Row layout decode from the current configuration.
   assign has_obj   = (cfg.layout_mode == LAYOUT_OBJ);
   assign base      = has_obj ? POS_W'(5) : POS_W'(4);
   assign ncls      = (cfg.num_classes > CLASS_W'(MAX_CLASSES)) ? CLASS_W'(MAX_CLASSES)
                                                                : cfg.num_classes;
   assign class_end = {1'b0, base} + {{(POS_W+1-CLASS_W){1'b0}}, ncls};
   assign in_class  = (position_ff >= base) && ({1'b0, position_ff} < class_end);
   assign k         = CLASS_W'(position_ff - base);

   // Row state with the current value folded in.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         box_upd[i] = box_ff[i];
      end
      obj_upd   = obj_ff;
      best_upd  = best_ff;
      index_upd = index_ff;
      if (position_ff < POS_W'(4)) begin
         box_upd[position_ff[1:0]] = v;
      end else if (has_obj && position_ff == POS_W'(4)) begin
         obj_upd = v;
      end else if (in_class && (k == '0 || v > best_ff)) begin
         best_upd  = v;
         index_upd = k;
      end
   end

   // Next state: hold when idle, clear at the end of a row.
   always_comb begin
      position_in = position_ff;
      best_in     = best_ff;
      index_in    = index_ff;
      obj_in      = obj_ff;
      for (int i = 0; i < 4; i++) begin
         box_in[i] = box_ff[i];
      end
      if (accept) begin
         if (req_tlast) begin
            position_in = '0;
            best_in     = '0;
            index_in    = '0;
            obj_in      = '0;
            for (int i = 0; i < 4; i++) begin
               box_in[i] = '0;
            end
         end else begin
            position_in = (position_ff == POS_MAX) ? position_ff : position_ff + 1'b1;
            best_in     = best_upd;
            index_in    = index_upd;
            obj_in      = obj_upd;
            for (int i = 0; i < 4; i++) begin
               box_in[i] = box_upd[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         best_ff     <= '0;
         index_ff    <= '0;
         obj_ff      <= '0;
         for (int i = 0; i < 4; i++) begin
            box_ff[i] <= '0;
         end
      end else begin
         position_ff <= position_in;
         best_ff     <= best_in;
         index_ff    <= index_in;
         obj_ff      <= obj_in;
         for (int i = 0; i < 4; i++) begin
            box_ff[i] <= box_in[i];
         end
      end
   end

   // Row record: the padding offset is taken off the centres here.
   assign pad_x_s = {{(REL_W-PAD_W-FRAC_BITS){1'b0}}, cfg.pad_x, {FRAC_BITS{1'b0}}};
   assign pad_y_s = {{(REL_W-PAD_W-FRAC_BITS){1'b0}}, cfg.pad_y, {FRAC_BITS{1'b0}}};

   always_comb begin
      push_rec.best_score = best_upd;
      push_rec.best_index = index_upd;
      push_rec.objectness = obj_upd;
      push_rec.rel_x      = REL_W'(box_upd[0]) - $signed(pad_x_s);
      push_rec.rel_y      = REL_W'(box_upd[1]) - $signed(pad_y_s);
      push_rec.size_w     = box_upd[2];
      push_rec.size_h     = box_upd[3];
      push_rec.seen       = (ncls != '0) && (position_ff >= base);
   end

endmodule

`default_nettype wire

// ----- rtl/core/dbd_queue.sv -----
`default_nettype none

module dbd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  dbd_pkg::row_rec_type push_rec,
   input  logic                 pop,
   output dbd_pkg::row_rec_type pop_rec,
   output logic                 full,
   output logic                 empty
);
   import dbd_pkg::*;

   row_rec_type         store_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_rec = store_ff[rd_ptr_ff];

   // Pointer and occupancy bookkeeping.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Record storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/dbd_back.sv -----
`default_nettype none

module dbd_back (
   input  logic                                clock,
   input  logic                                reset,
   input  dbd_pkg::cfg_type                    cfg,
   input  logic                                queue_empty,
   input  dbd_pkg::row_rec_type                queue_rec,
   output logic                                queue_pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [dbd_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   import dbd_pkg::*;

   localparam logic [SZ_W-1:0]   N_BIAS  = {{(SZ_W-2*FRAC_BITS){1'b0}},
                                            {(2*FRAC_BITS){1'b1}}};
   localparam logic [EDGE_W-1:0] LO_BIAS = {{(EDGE_W-2*FRAC_BITS-1){1'b0}},
                                            {(2*FRAC_BITS+1){1'b1}}};

   logic advance;
   logic has_obj;
   logic signed [INV_W:0] inv_s;

   // Stage 1: products.
   logic                       s1_valid_ff, s1_valid_in;
   logic signed [PROD_W-1:0]   s1_prod_ff, s1_prod_in;
   logic signed [VALUE_W-1:0]  s1_best_ff, s1_best_in;
   logic [CLASS_W-1:0]         s1_index_ff, s1_index_in;
   logic                       s1_seen_ff, s1_seen_in;
   logic signed [SZ_W-1:0]     s1_szx_ff, s1_szx_in, s1_szy_ff, s1_szy_in;
   logic signed [RINV_W-1:0]   s1_rx_ff, s1_rx_in, s1_ry_ff, s1_ry_in;

   // Stage 2: edges, sizes and confidence.
   logic                       s2_valid_ff, s2_valid_in;
   logic signed [CONF_W-1:0]   s2_conf_ff, s2_conf_in;
   logic [CLASS_W-1:0]         s2_index_ff, s2_index_in;
   logic                       s2_seen_ff, s2_seen_in;
   logic signed [EDGE_W-1:0]   s2_ex_ff, s2_ex_in, s2_ey_ff, s2_ey_in;
   logic signed [N_W-1:0]      s2_nx_ff, s2_nx_in, s2_ny_ff, s2_ny_in;
   logic signed [SZ_W-1:0]     szx_b, szy_b;

   // Stage 3: whole-pixel starts and threshold test.
   logic                       s3_valid_ff, s3_valid_in;
   logic                       s3_keep_ff, s3_keep_in;
   logic [CONF_OUT_W-1:0]      s3_conf_ff, s3_conf_in;
   logic [CLASS_W-1:0]         s3_index_ff, s3_index_in;
   logic signed [LO_W-1:0]     s3_lox_ff, s3_lox_in, s3_loy_ff, s3_loy_in;
   logic signed [N_W-1:0]      s3_nx_ff, s3_nx_in, s3_ny_ff, s3_ny_in;
   logic signed [EDGE_W-1:0]   ex_b, ey_b;
   logic signed [LO_W-1:0]     lox, loy;

   // Stage 4: far edges against the frame.
   logic                       s4_valid_ff, s4_valid_in;
   logic                       s4_keep_ff, s4_keep_in;
   logic [CONF_OUT_W-1:0]      s4_conf_ff, s4_conf_in;
   logic [CLASS_W-1:0]         s4_index_ff, s4_index_in;
   logic signed [LO_W-1:0]     s4_lox_ff, s4_lox_in, s4_loy_ff, s4_loy_in;
   logic signed [N_W-1:0]      s4_nx_ff, s4_nx_in, s4_ny_ff, s4_ny_in;
   logic signed [SUM_W-1:0]    s4_sumx_ff, s4_sumx_in, s4_sumy_ff, s4_sumy_in;
   logic signed [SUM_W-1:0]    s4_difx_ff, s4_difx_in, s4_dify_ff, s4_dify_in;
   logic [DIM_W-1:0]           lim_x, lim_y;
   logic signed [SUM_W-1:0]    lim_xs, lim_ys;

   // Output register.
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_fields_type             rsp_data_ff, rsp_data_in;
   logic signed [SUM_W-1:0]    wd, ht;

   // The whole pipeline moves when the output register is free or taken.
   assign advance   = !rsp_valid_ff || rsp_tready;
   assign queue_pop = advance && !queue_empty;
   assign has_obj   = (cfg.layout_mode == LAYOUT_OBJ);
   assign inv_s     = $signed({1'b0, cfg.inv_scale});

   assign lim_x  = (cfg.frame_width  > DIM_MAX) ? DIM_MAX : cfg.frame_width;
   assign lim_y  = (cfg.frame_height > DIM_MAX) ? DIM_MAX : cfg.frame_height;
   assign lim_xs = $signed({{(SUM_W-DIM_W){1'b0}}, lim_x});
   assign lim_ys = $signed({{(SUM_W-DIM_W){1'b0}}, lim_y});

   // Stage 1: one multiplier per product, all in parallel.
   always_comb begin
      s1_valid_in = !queue_empty;
      s1_prod_in  = PROD_W'(queue_rec.best_score) * PROD_W'(queue_rec.objectness);
      s1_best_in  = queue_rec.best_score;
      s1_index_in = queue_rec.best_index;
      s1_seen_in  = queue_rec.seen;
      s1_szx_in   = SZ_W'(queue_rec.size_w) * SZ_W'(inv_s);
      s1_szy_in   = SZ_W'(queue_rec.size_h) * SZ_W'(inv_s);
      s1_rx_in    = RINV_W'(queue_rec.rel_x) * RINV_W'(inv_s);
      s1_ry_in    = RINV_W'(queue_rec.rel_y) * RINV_W'(inv_s);
   end

   // Stage 2: doubled start edge, truncated size and confidence.
   always_comb begin
      s2_valid_in = s1_valid_ff;
      s2_index_in = s1_index_ff;
      s2_seen_in  = s1_seen_ff;
      s2_conf_in  = has_obj ? CONF_W'(s1_prod_ff >>> FRAC_BITS) : CONF_W'(s1_best_ff);
      s2_ex_in    = (EDGE_W'(s1_rx_ff) <<< 1) - EDGE_W'(s1_szx_ff);
      s2_ey_in    = (EDGE_W'(s1_ry_ff) <<< 1) - EDGE_W'(s1_szy_ff);
      // Truncation toward zero: bias negative values before the shift.
      szx_b       = s1_szx_ff + $signed(s1_szx_ff[SZ_W-1] ? N_BIAS : '0);
      szy_b       = s1_szy_ff + $signed(s1_szy_ff[SZ_W-1] ? N_BIAS : '0);
      s2_nx_in    = N_W'(szx_b >>> (2 * FRAC_BITS));
      s2_ny_in    = N_W'(szy_b >>> (2 * FRAC_BITS));
   end

   // Stage 3: start edge to whole pixels, clipped at zero; threshold test and confidence saturation.
   always_comb begin
      s3_valid_in = s2_valid_ff;
      s3_index_in = s2_index_ff;
      s3_nx_in    = s2_nx_ff;
      s3_ny_in    = s2_ny_ff;
      ex_b        = s2_ex_ff + $signed(s2_ex_ff[EDGE_W-1] ? LO_BIAS : '0);
      ey_b        = s2_ey_ff + $signed(s2_ey_ff[EDGE_W-1] ? LO_BIAS : '0);
      lox         = LO_W'(ex_b >>> (2 * FRAC_BITS + 1));
      loy         = LO_W'(ey_b >>> (2 * FRAC_BITS + 1));
      s3_lox_in   = lox[LO_W-1] ? '0 : lox;
      s3_loy_in   = loy[LO_W-1] ? '0 : loy;
      s3_keep_in  = s2_seen_ff
                    && (s2_conf_ff >= $signed({{(CONF_W-THR_W){1'b0}}, cfg.conf_threshold}));
      s3_conf_in  = (s2_conf_ff > $signed(CONF_W'(32'h7FFF_FFFF))) ? '1
                                                                 : s2_conf_ff[CONF_OUT_W-1:0];
   end

   // Stage 4: far edge and room left in the frame.
   always_comb begin
      s4_valid_in = s3_valid_ff;
      s4_keep_in  = s3_keep_ff;
      s4_conf_in  = s3_conf_ff;
      s4_index_in = s3_index_ff;
      s4_lox_in   = s3_lox_ff;
      s4_loy_in   = s3_loy_ff;
      s4_nx_in    = s3_nx_ff;
      s4_ny_in    = s3_ny_ff;
      s4_sumx_in  = SUM_W'(s3_lox_ff) + SUM_W'(s3_nx_ff);
      s4_sumy_in  = SUM_W'(s3_loy_ff) + SUM_W'(s3_ny_ff);
      s4_difx_in  = lim_xs - SUM_W'(s3_lox_ff);
      s4_dify_in  = lim_ys - SUM_W'(s3_loy_ff);
   end

   // Final clamp, size check and result formatting.
   always_comb begin
      wd = (s4_sumx_ff > lim_xs) ? s4_difx_ff : SUM_W'(s4_nx_ff);
      ht = (s4_sumy_ff > lim_ys) ? s4_dify_ff : SUM_W'(s4_ny_ff);
      rsp_valid_in             = s4_valid_ff && s4_keep_ff
                                 && (wd >= SUM_W'(1)) && (ht >= SUM_W'(1));
      rsp_data_in              = '0;
      rsp_data_in.box_left     = s4_lox_ff[COORD_W-1:0];
      rsp_data_in.box_top      = s4_loy_ff[COORD_W-1:0];
      rsp_data_in.box_width    = wd[DIM_W-1:0];
      rsp_data_in.box_height   = ht[DIM_W-1:0];
      rsp_data_in.class_index  = s4_index_ff;
      rsp_data_in.confidence   = s4_conf_ff;
   end

   // Stage valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         s4_valid_ff  <= s4_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Stage payloads.
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_prod_ff  <= s1_prod_in;
         s1_best_ff  <= s1_best_in;
         s1_index_ff <= s1_index_in;
         s1_seen_ff  <= s1_seen_in;
         s1_szx_ff   <= s1_szx_in;
         s1_szy_ff   <= s1_szy_in;
         s1_rx_ff    <= s1_rx_in;
         s1_ry_ff    <= s1_ry_in;

         s2_conf_ff  <= s2_conf_in;
         s2_index_ff <= s2_index_in;
         s2_seen_ff  <= s2_seen_in;
         s2_ex_ff    <= s2_ex_in;
         s2_ey_ff    <= s2_ey_in;
         s2_nx_ff    <= s2_nx_in;
         s2_ny_ff    <= s2_ny_in;

         s3_keep_ff  <= s3_keep_in;
         s3_conf_ff  <= s3_conf_in;
         s3_index_ff <= s3_index_in;
         s3_lox_ff   <= s3_lox_in;
         s3_loy_ff   <= s3_loy_in;
         s3_nx_ff    <= s3_nx_in;
         s3_ny_ff    <= s3_ny_in;

         s4_keep_ff  <= s4_keep_in;
         s4_conf_ff  <= s4_conf_in;
         s4_index_ff <= s4_index_in;
         s4_lox_ff   <= s4_lox_in;
         s4_loy_ff   <= s4_loy_in;
         s4_nx_ff    <= s4_nx_in;
         s4_ny_ff    <= s4_ny_in;
         s4_sumx_ff  <= s4_sumx_in;
         s4_sumy_ff  <= s4_sumy_in;
         s4_difx_ff  <= s4_difx_in;
         s4_dify_ff  <= s4_dify_in;

         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/detector_box_decode.sv -----
// A result reaches rsp through the queue, back stages 1 to 4 and the output register.
// One value per cycle while the queue is not full; a row may end every cycle. The front row tracker and
// the five-stage back pipeline both take one entry per cycle, with a four-entry queue between.
// An output stall halts the back pipeline; the front keeps taking values until the queue fills.
// Reset is synchronous and active high; it clears the row state, the queue, the pipeline
// and restores every configuration register to its default.
`default_nettype none

module detector_box_decode (
   input  logic                                clock,
   input  logic                                reset,
   // Input stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [31:0]                         req_tdata,   // value
   input  logic                                req_tlast,   // row_end
   // Result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // box_left, box_top, box_width, box_height, class_index, confidence, zero fill
   output logic [dbd_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // Configuration writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dbd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [dbd_pkg::CSR_DATA_W-1:0]      csr_data
);
   import dbd_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   logic        queue_full, queue_empty;
   logic        push, pop;
   row_rec_type push_rec, pop_rec;

   assign csr_ready = 1'b1;

   // Configuration register file.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_LAYOUT_MODE:    cfg_in.layout_mode    = csr_data[1:0];
            REG_NUM_CLASSES:    cfg_in.num_classes    = csr_data[CLASS_W-1:0];
            REG_CONF_THRESHOLD: cfg_in.conf_threshold = csr_data[THR_W-1:0];
            REG_INV_SCALE:      cfg_in.inv_scale      = csr_data[INV_W-1:0];
            REG_PAD_X:          cfg_in.pad_x          = csr_data[PAD_W-1:0];
            REG_PAD_Y:          cfg_in.pad_y          = csr_data[PAD_W-1:0];
            REG_FRAME_WIDTH:    cfg_in.frame_width    = csr_data[DIM_W-1:0];
            REG_FRAME_HEIGHT:   cfg_in.frame_height   = csr_data[DIM_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dbd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .push_rec   (push_rec)
   );

   dbd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .pop_rec  (pop_rec),
      .full     (queue_full),
      .empty    (queue_empty)
   );

   dbd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_empty (queue_empty),
      .queue_rec   (pop_rec),
      .queue_pop   (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

`default_nettype wire

// ----- rtl/core/dbd_checker.sv -----
`default_nettype none

module dbd_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [dbd_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import dbd_pkg::*;

   rsp_fields_type rsp;

   assign rsp = rsp_tdata;

   // A stalled result stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed or vanished while stalled");

   // No result is offered in the cycle after a reset.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered straight after reset");

   // A kept box is at least one pixel in each direction.
   a_min_size: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp.box_width != '0 && rsp.box_height != '0)
      else $error("result box has zero size");

   // A full-frame extent only starts at the frame edge.
   a_full_extent: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp.box_width[DIM_W-1] || rsp.box_left == '0)
                     && (!rsp.box_height[DIM_W-1] || rsp.box_top == '0))
      else $error("box runs past the frame edge");

endmodule

bind detector_box_decode dbd_checker u_dbd_checker (.*);

`default_nettype wire

// ----- dv/detector_box_decode_tb.sv -----
`timescale 1ns / 100ps

module detector_box_decode_tb;
   import dbd_pkg::*;

   localparam int CYCLE_LIMIT      = 400000;
   localparam int SETTLE_CYCLES    = 64;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int BOX_VALUES       = 4;
   localparam int RANDOM_VALUES    = 380;
   localparam int EXTREME_PHASES   = 8;
   localparam int PHASE_VALUES     = 12;
   localparam longint CONF_SAT     = (longint'(1) <<< CONF_OUT_W) - 1;

   // Layout code with no meaning of its own; the block treats it as the plain layout.
   localparam logic [1:0] LAYOUT_SPARE = 2'd3;

   typedef enum {ROW_CLEAN, ROW_SHORT, ROW_LONG, ROW_NOISE} row_kind_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [VALUE_W-1:0]     req_tdata;   // value
   logic                   req_tlast;   // row_end
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // box_left, box_top, box_width, box_height, class_index, confidence, zero fill
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   // Tracks each prediction row as it streams in and queues the boxes it should yield.
   class box_decode_scoreboard;
      cfg_type                   regs;
      logic [POS_W-1:0]          position;
      logic signed [VALUE_W-1:0] best_score;
      logic [CLASS_W-1:0]        best_index;
      logic signed [VALUE_W-1:0] box_vals [BOX_VALUES];
      logic signed [VALUE_W-1:0] objectness;
      rsp_fields_type            pending_boxes [$];
      int                        fail_count;

      function new();
         regs = CFG_RESET;
         fail_count = 0;
         clear_row();
      endfunction

      function void clear_row();
         position = '0;
         best_score = '0;
         best_index = '0;
         objectness = '0;
         foreach (box_vals[i]) box_vals[i] = '0;
      endfunction

      function void set_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_LAYOUT_MODE:    regs.layout_mode    = data[1:0];
            REG_NUM_CLASSES:    regs.num_classes    = data[CLASS_W-1:0];
            REG_CONF_THRESHOLD: regs.conf_threshold = data[THR_W-1:0];
            REG_INV_SCALE:      regs.inv_scale      = data[INV_W-1:0];
            REG_PAD_X:          regs.pad_x          = data[PAD_W-1:0];
            REG_PAD_Y:          regs.pad_y          = data[PAD_W-1:0];
            REG_FRAME_WIDTH:    regs.frame_width    = data[DIM_W-1:0];
            REG_FRAME_HEIGHT:   regs.frame_height   = data[DIM_W-1:0];
            default: ;
         endcase
      endfunction

      // Shift right, rounding towards zero.
      function longint trunc_shift(longint x, int s);
         return (x >= 0) ? (x >>> s) : -((-x) >>> s);
      endfunction

      // Undoes the letterbox on one axis and clamps to the frame; false if the box is lost.
      function bit map_axis(logic signed [VALUE_W-1:0] centre, logic signed [VALUE_W-1:0] size,
                            logic [PAD_W-1:0] pad, logic [DIM_W-1:0] frame_dim,
                            output logic [COORD_W-1:0] first_px,
                            output logic [DIM_W-1:0] span_px);
         longint inv, rel, scaled, lo, n, dim;
         inv = longint'(regs.inv_scale);
         rel = longint'(centre) - (longint'(pad) <<< FRAC_BITS);
         scaled = longint'(size) * inv;
         lo = trunc_shift(2 * rel * inv - scaled, 2 * FRAC_BITS + 1);
         n = trunc_shift(scaled, 2 * FRAC_BITS);
         dim = (frame_dim > DIM_MAX) ? longint'(DIM_MAX) : longint'(frame_dim);
         if (lo < 0) lo = 0;
         if (lo + n > dim) n = dim - lo;
         first_px = lo[COORD_W-1:0];
         span_px = n[DIM_W-1:0];
         return n >= 1;
      endfunction

      // Notes one accepted input transaction; at the end of a row it may queue a box.
      function void take_value(logic [VALUE_W-1:0] raw, logic row_end);
         logic signed [VALUE_W-1:0] v;
         bit                        has_obj;
         bit                        keep;
         int unsigned               base;
         int unsigned               p;
         int unsigned               k;
         longint                    conf;
         rsp_fields_type            box;
         v = raw;
         has_obj = (regs.layout_mode == LAYOUT_OBJ);
         base = BOX_VALUES + int'(has_obj);
         p = position;
         if (p < BOX_VALUES) begin
            box_vals[p] = v;
         end else if (has_obj && p == BOX_VALUES) begin
            objectness = v;
         end else if (p >= base && p < base + regs.num_classes) begin
            k = p - base;
            if (k == 0 || v > best_score) begin
               best_score = v;
               best_index = k[CLASS_W-1:0];
            end
         end
         if (position != POS_MAX) position = position + 1'b1;
         if (!row_end) return;

         if (has_obj) conf = (longint'(best_score) * longint'(objectness)) >>> FRAC_BITS;
         else conf = longint'(best_score);
         keep = regs.num_classes != 0 && p >= base && conf >= longint'(regs.conf_threshold);
         box = '0;
         if (keep)
            keep = map_axis(box_vals[0], box_vals[2], regs.pad_x, regs.frame_width,
                            box.box_left, box.box_width)
                && map_axis(box_vals[1], box_vals[3], regs.pad_y, regs.frame_height,
                            box.box_top, box.box_height);
         if (keep) begin
            box.class_index = best_index;
            box.confidence = CONF_OUT_W'((conf > CONF_SAT) ? CONF_SAT : conf);
            pending_boxes = {pending_boxes, box};
         end
         clear_row();
      endfunction

      function void note_fail(string msg);
         fail_count++;
         if (fail_count <= 10) $display("mismatch at %0t: %s", $time, msg);
      endfunction

      function void compare_field(string name, longint want, longint got);
         if (want != got) note_fail($sformatf("%s expected %0d, got %0d", name, want, got));
      endfunction

      // Checks one result transaction against the oldest queued box.
      function void check_box(rsp_fields_type got);
         rsp_fields_type want;
         if (pending_boxes.size() == 0) begin
            note_fail($sformatf("result with no row pending, data %h", got));
            return;
         end
         want = pending_boxes[0];
         pending_boxes.delete(0);
         compare_field("box_left", want.box_left, got.box_left);
         compare_field("box_top", want.box_top, got.box_top);
         compare_field("box_width", want.box_width, got.box_width);
         compare_field("box_height", want.box_height, got.box_height);
         compare_field("class_index", want.class_index, got.class_index);
         compare_field("confidence", want.confidence, got.confidence);
      endfunction
   endclass

   box_decode_scoreboard scoreboard;
   logic [VALUE_W-1:0]   row_vals [$];
   int                   values_sent = 0;
   int                   cycle_count = 0;
   bit                   req_idling = 1'b1;
   bit                   rsp_idling = 1'b1;
   bit                   long_hold = 1'b0;

   detector_box_decode uut (
      .clock,
      .reset,
      .req_tvalid,
      .req_tready,
      .req_tdata,
      .req_tlast,
      .rsp_tvalid,
      .rsp_tready,
      .rsp_tdata,
      .csr_valid,
      .csr_ready,
      .csr_index,
      .csr_data
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Guard against a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Every accepted result transaction is checked at the edge that takes it.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         scoreboard.check_box(rsp_fields_type'(rsp_tdata));
   end

   // Result side readiness: random stall bursts, plus one long hold when asked for.
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
            rsp_tready <= 1'b1;
         end else if (rsp_idling && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      scoreboard.set_reg(idx, data);
   endtask

   // Writes every register in turn; only called while the block is idle.
   task automatic write_settings(input logic [1:0] layout, input int ncls, input int thr,
                                 input int inv, input int px, input int py,
                                 input int fw, input int fh);
      write_reg(REG_LAYOUT_MODE, CSR_DATA_W'(layout));
      write_reg(REG_NUM_CLASSES, CSR_DATA_W'(ncls));
      write_reg(REG_CONF_THRESHOLD, CSR_DATA_W'(thr));
      write_reg(REG_INV_SCALE, CSR_DATA_W'(inv));
      write_reg(REG_PAD_X, CSR_DATA_W'(px));
      write_reg(REG_PAD_Y, CSR_DATA_W'(py));
      write_reg(REG_FRAME_WIDTH, CSR_DATA_W'(fw));
      write_reg(REG_FRAME_HEIGHT, CSR_DATA_W'(fh));
      csr_valid <= 1'b0;
   endtask

   // Offers one value, after an optional idle burst, and waits for the transaction.
   task automatic send_value(input logic [VALUE_W-1:0] v, input logic row_end);
      if (req_idling && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      req_tlast  <= row_end;
      do @(posedge clock); while (!req_tready);
      scoreboard.take_value(v, row_end);
      values_sent++;
   endtask

   task automatic send_row();
      foreach (row_vals[i]) send_value(row_vals[i], i == row_vals.size() - 1);
   endtask

   // Holds the input back until every queued box has come out.
   task automatic wait_boxes_out();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (scoreboard.pending_boxes.size() != 0);
   endtask

   // Lets dropped rows still in the back pipeline leave before anything is reconfigured.
   task automatic wait_quiet();
      wait_boxes_out();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Builds one row for the current layout; clean rows carry plausible boxes and scores.
   function automatic void build_row(row_kind_type kind, int extra);
      int                 base;
      int                 full;
      int                 len;
      bit                 has_obj;
      logic [PAD_W-1:0]   pad;
      logic [VALUE_W-1:0] item;
      has_obj = (scoreboard.regs.layout_mode == LAYOUT_OBJ);
      base = BOX_VALUES + int'(has_obj);
      full = base + scoreboard.regs.num_classes
           + int'(scoreboard.regs.layout_mode == LAYOUT_ANGLE);
      case (kind)
         ROW_SHORT: len = $urandom_range(1, full - 1);
         ROW_LONG:  len = full + extra;
         ROW_NOISE: len = $urandom_range(1, full + 2);
         default:   len = full;
      endcase
      row_vals.delete();
      for (int i = 0; i < len; i++) begin
         if (kind == ROW_NOISE) begin
            item = $urandom;
         end else if (i < 2) begin
            pad = (i == 0) ? scoreboard.regs.pad_x : scoreboard.regs.pad_y;
            item = {16'(pad + $urandom_range(0, 700)), 16'($urandom)};
         end else if (i < BOX_VALUES) begin
            item = {16'($urandom_range(0, 400)), 16'($urandom)};
         end else if (has_obj && i == BOX_VALUES) begin
            item = VALUE_W'($urandom_range(0, 98304));
         end else if (i > base && $urandom_range(0, 7) == 0) begin
            // Repeat the previous score so that ties keep the earlier index.
            item = row_vals[i - 1];
         end else if ($urandom_range(0, 15) == 0) begin
            item = $urandom | 32'h8000_0000;
         end else begin
            item = VALUE_W'($urandom_range(0, 98304));
         end
         row_vals = {row_vals, item};
      end
   endfunction

   // Random rows under the current settings, mostly well formed.
   task automatic run_phase(input int budget, input bit allow_idle);
      int           start;
      int           r;
      row_kind_type kind;
      start = values_sent;
      req_idling = allow_idle && ($urandom_range(0, 3) != 0);
      rsp_idling = allow_idle && ($urandom_range(0, 3) != 0);
      while (values_sent - start < budget) begin
         r = $urandom_range(0, 9);
         kind = (r < 7) ? ROW_CLEAN : (r == 7) ? ROW_SHORT : (r == 8) ? ROW_LONG : ROW_NOISE;
         build_row(kind, $urandom_range(1, 5));
         send_row();
         if ($urandom_range(0, 15) == 0) wait_boxes_out();
      end
      wait_quiet();
   endtask

   initial begin
      int random_start;
      int phase_count;
      scoreboard = new();
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      csr_valid  <= 1'b0;
      csr_index  <= '0;
      csr_data   <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed rows: value extremes, a tie, an early end and each layout.
      write_settings(LAYOUT_PLAIN, 2, 16384, 65536, 0, 0, 640, 640);
      row_vals = {32'h0140_0000, 32'h00F0_0000, 32'h0064_0000, 32'h0032_0000,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF};
      send_row();
      row_vals = {32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF};
      send_row();
      row_vals = {32'h0000_0000, 32'h0000_0000, 32'h0280_0000, 32'h0280_0000,
                  32'h8000_0000, 32'h0000_4000};
      send_row();
      wait_quiet();
      write_settings(LAYOUT_OBJ, 2, 16384, 65536, 0, 0, 640, 640);
      row_vals = {32'h0140_0000, 32'h00F0_0000, 32'h0064_0000, 32'h0032_0000,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
      send_row();
      wait_quiet();
      write_settings(LAYOUT_ANGLE, 2, 16384, 65536, 0, 0, 640, 640);
      row_vals = {32'h0140_0000, 32'h00F0_0000, 32'h0064_0000, 32'h0032_0000,
                  32'h0001_0000, 32'h0000_8000, 32'hDEAD_BEEF};
      send_row();
      wait_quiet();

      // Back-pressure: the result side holds off while clean rows keep coming,
      // then one row that runs past its layout.
      write_settings(LAYOUT_PLAIN, 1, 16384, 65536, 0, 0, 640, 640);
      req_idling = 1'b0;
      long_hold = 1'b1;
      repeat (12) begin
         build_row(ROW_CLEAN, 0);
         send_row();
      end
      build_row(ROW_LONG, 5);
      send_row();
      wait_quiet();

      // Extreme settings first, then random ones.
      random_start = values_sent;
      phase_count = 0;
      while (phase_count < EXTREME_PHASES
             || (values_sent - random_start < RANDOM_VALUES && phase_count < 40)) begin
         case (phase_count)
            0: write_settings(LAYOUT_OBJ, 4, 4096, 49152, 12, 80, 960, 540);
            1: write_settings(LAYOUT_ANGLE, 255, 65536, 16777215, 0, 0, 8191, 4096);
            2: write_settings(LAYOUT_SPARE, 1, 0, 1, 0, 4095, 1, 1);
            3: write_settings(LAYOUT_PLAIN, 0, 16384, 65536, 0, 0, 640, 640);
            4: write_settings(LAYOUT_PLAIN, 5, 0, 0, 0, 0, 640, 640);
            5: write_settings(LAYOUT_OBJ, 2, 131071, 65536, 0, 0, 0, 640);
            6: write_settings(LAYOUT_ANGLE, 3, 8192, 65536, 0, 0, 4096, 8191);
            7: write_settings(LAYOUT_PLAIN, 2, 16384, 131072, 4095, 4095, 4096, 4096);
            default:
               write_settings(2'($urandom_range(0, 3)), $urandom_range(1, 8),
                              $urandom_range(0, 40000), $urandom_range(32768, 131072),
                              $urandom_range(0, 200), $urandom_range(0, 200),
                              $urandom_range(64, 4096), $urandom_range(64, 4096));
         endcase
         run_phase(PHASE_VALUES, 1'b1);
         phase_count++;
      end

      // Closing stretch with neither side idling.
      write_settings(LAYOUT_OBJ, 3, 8192, 65536, 0, 0, 1280, 720);
      run_phase(20, 1'b0);

      if (scoreboard.fail_count == 0 && scoreboard.pending_boxes.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
